@@ src/pip_pkg.sv @@
`default_nettype none
package pip_pkg;
    localparam int MaxVerticesDefault = 16;
    localparam int CoordW = 16;
    localparam int SlopeW = 32;
    localparam int IcptW  = 48;
    localparam int CountW = 5;

    localparam logic [1:0] ModeLoad   = 2'd0;
    localparam logic [1:0] ModeCommit = 2'd1;
    localparam logic [1:0] ModeQuery  = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic       in_poly;
    } t_result;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic cap;
        logic div_start;
        logic wr_edge;
        logic step;
        logic clr;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_status;
endpackage
`default_nettype wire

@@ src/pip_if.sv @@
`default_nettype none
interface pip_req_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           mode;
    logic [3:0]           vertex_index;
    logic signed [15:0]   coord_x;
    logic signed [15:0]   coord_y;
    modport source (output valid, mode, vertex_index, coord_x, coord_y, input ready);
    modport sink   (input valid, mode, vertex_index, coord_x, coord_y, output ready);
endinterface

interface pip_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] reply_kind;
    logic       inside_res;
    modport source (output valid, reply_kind, inside_res, input ready);
    modport sink   (input valid, reply_kind, inside_res, output ready);
endinterface

interface pip_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

@@ src/point_in_polygon_test_top.sv @@
`default_nettype none
// Even-odd point-in-polygon test for one polygon of up to MaxVertices vertices.
// Request channel i_req: mode 0 stores a vertex, mode 1 commits the edge
// coefficients, mode 2 queries a point. Every request yields one reply on o_rsp.
// A load or unused mode presents its reply in the cycle right after acceptance.
// A query reads the vertex memories in S_QREAD and does the compare in
// S_QSTEP for each edge, then registers the answer in S_QEND.
// A commit runs the shared serial divider twice per non-horizontal edge; a
// horizontal edge skips the divider and is written in S_CDIV.
// One request is in flight at a time; the reply register holds the reply
// while the receiver stalls, and no request is taken until it is consumed.
// Configuration channel i_cfg writes vertex_count and is always ready; write
// it only while idle.
// Reset clears the count, the edge valid bits (so edges read as zero) and the
// control state. Vertex slots are undefined until loaded.
module point_in_polygon_test_top #(
    parameter int MaxVertices = pip_pkg::MaxVerticesDefault
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pip_req_if.sink    i_req,
    pip_rsp_if.source  o_rsp,
    pip_cfg_if.sink    i_cfg
);
    import pip_pkg::*;
    localparam int IdxW = $clog2(MaxVertices);
    logic [CountW-1:0] r_count;
    t_cmd w_cmd;
    t_status w_status;
    t_result w_res;
    logic [IdxW-1:0] w_edge, w_pred;
    logic w_inside;

    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_count <= '0;
        else if (i_cfg.valid) r_count <= i_cfg.data;
    end

    pip_ctrl #(.MaxVertices(MaxVertices)) u_ctrl (.i_clk, .i_rst_n,
        .i_valid(i_req.valid), .o_ready(i_req.ready), .i_mode(i_req.mode),
        .i_count(r_count), .o_cmd(w_cmd), .i_status(w_status), .o_edge(w_edge),
        .o_pred(w_pred), .i_inside(w_inside), .o_rvalid(o_rsp.valid),
        .i_rready(o_rsp.ready), .o_res(w_res));

    pip_datapath #(.MaxVertices(MaxVertices)) u_dp (.i_clk, .i_rst_n,
        .i_cmd(w_cmd), .o_status(w_status), .i_vidx(i_req.vertex_index),
        .i_cx(i_req.coord_x), .i_cy(i_req.coord_y), .i_edge(w_edge),
        .i_pred(w_pred), .o_inside(w_inside));

    assign o_rsp.reply_kind = w_res.kind;
    assign o_rsp.inside_res = w_res.in_poly;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !i_req.ready) else $error("request taken with reply pending");
    a_inside_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.reply_kind != ModeQuery) |-> !o_rsp.inside_res)
        else $error("inside set on non-query reply");
`endif
endmodule
`default_nettype wire

@@ src/pip_ram.sv @@
`default_nettype none
module pip_ram #(
    parameter int Width = 16,
    parameter int Depth = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ src/pip_div.sv @@
`default_nettype none
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
module pip_div #(
    parameter int NumW = 40,
    parameter int DenW = 17
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic signed [NumW-1:0] i_num,
    input  wire logic signed [DenW-1:0] i_den,
    output logic                        o_done,
    output logic signed [NumW-1:0]      o_quot
);
    localparam int CntW = $clog2(NumW + 1);
    logic [NumW-1:0] r_q, n_q;
    logic [DenW:0]   r_rem, n_rem;
    logic [DenW-1:0] r_d;
    logic            r_neg;
    logic [CntW-1:0] r_cnt;
    logic            r_busy;
    logic [DenW:0]   w_trial;

    always_comb begin
        w_trial = {r_rem[DenW-1:0], r_q[NumW-1]} - {1'b0, r_d};
        if (!w_trial[DenW]) begin
            n_rem = w_trial;
            n_q   = {r_q[NumW-2:0], 1'b1};
        end else begin
            n_rem = {r_rem[DenW-1:0], r_q[NumW-1]};
            n_q   = {r_q[NumW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(NumW);
                r_q    <= i_num[NumW-1] ? -i_num : i_num;
                r_d    <= i_den[DenW-1] ? -i_den : i_den;
                r_neg  <= i_num[NumW-1] ^ i_den[DenW-1];
                r_rem  <= '0;
            end else if (r_busy) begin
                r_q   <= n_q;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quot = r_neg ? -$signed(r_q) : $signed(r_q);
endmodule
`default_nettype wire

@@ src/pip_datapath.sv @@
`default_nettype none
module pip_datapath #(
    parameter int MaxVertices = pip_pkg::MaxVerticesDefault
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire pip_pkg::t_cmd        i_cmd,
    output pip_pkg::t_status          o_status,
    input  wire logic [3:0]           i_vidx,
    input  wire logic signed [15:0]   i_cx,
    input  wire logic signed [15:0]   i_cy,
    input  wire logic [$clog2(MaxVertices)-1:0] i_edge,
    input  wire logic [$clog2(MaxVertices)-1:0] i_pred,
    output logic                      o_inside
);
    import pip_pkg::*;
    localparam int IdxW = $clog2(MaxVertices);

    logic [CoordW-1:0] w_x_cur, w_y_cur, w_x_prv, w_y_prv;
    logic [SlopeW-1:0] w_slope;
    logic [IcptW-1:0]  w_icpt;
    logic [MaxVertices-1:0] r_evalid;
    logic              w_vwe;
    logic signed [39:0] w_num, w_q1, w_q2;
    logic               w_d1, w_d2;
    logic signed [16:0] w_dy;
    logic signed [16:0] w_dx;
    logic               r_phase2;
    logic signed [SlopeW-1:0] r_slope_res;
    logic signed [IcptW-1:0]  w_icpt_res;

    assign w_vwe = i_cmd.load && ({3'b0, i_vidx} < 7'(MaxVertices));

    pip_ram #(.Width(CoordW), .Depth(MaxVertices)) u_xc (.i_clk, .i_we(w_vwe),
        .i_waddr(IdxW'(i_vidx)), .i_wdata(i_cx), .i_raddr(i_edge), .o_rdata(w_x_cur));
    pip_ram #(.Width(CoordW), .Depth(MaxVertices)) u_yc (.i_clk, .i_we(w_vwe),
        .i_waddr(IdxW'(i_vidx)), .i_wdata(i_cy), .i_raddr(i_edge), .o_rdata(w_y_cur));
    pip_ram #(.Width(CoordW), .Depth(MaxVertices)) u_xp (.i_clk, .i_we(w_vwe),
        .i_waddr(IdxW'(i_vidx)), .i_wdata(i_cx), .i_raddr(i_pred), .o_rdata(w_x_prv));
    pip_ram #(.Width(CoordW), .Depth(MaxVertices)) u_yp (.i_clk, .i_we(w_vwe),
        .i_waddr(IdxW'(i_vidx)), .i_wdata(i_cy), .i_raddr(i_pred), .o_rdata(w_y_prv));

    assign w_dx = 17'($signed(w_x_prv)) - 17'($signed(w_x_cur));
    assign w_dy = 17'($signed(w_y_prv)) - 17'($signed(w_y_cur));

    // Phase one divides dx*65536 by dy, phase two divides y1*dx*256 by dy.
    logic signed [39:0] r_num;
    logic               r_go;
    assign w_num = (40'($signed(w_y_cur)) * 40'(w_dx)) <<< 8;
    pip_div #(.NumW(40), .DenW(17)) u_div (.i_clk, .i_rst_n, .i_start(r_go),
        .i_num(r_num), .i_den(w_dy), .o_done(w_d1), .o_quot(w_q1));
    assign w_d2 = w_d1;
    assign w_q2 = w_q1;

    assign w_icpt_res = (w_dy == '0) ? IcptW'($signed(w_x_cur)) <<< 8
                      : (IcptW'($signed(w_x_cur)) <<< 8) - IcptW'(w_q2);

    logic w_wr;
    assign w_wr = (w_dy == '0) ? i_cmd.wr_edge : (w_d2 && r_phase2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase2 <= 1'b0;
            r_go     <= 1'b0;
            r_evalid <= '0;
        end else begin
            r_go <= 1'b0;
            if (i_cmd.div_start && w_dy != '0) begin
                r_phase2 <= 1'b0;
                r_num    <= 40'(w_dx) <<< 16;
                r_go     <= 1'b1;
            end else if (w_d1 && !r_phase2) begin
                if (w_q1 > 40'sd2147483647) r_slope_res <= 32'h7fffffff;
                else if (w_q1 < -40'sd2147483648) r_slope_res <= 32'h80000000;
                else r_slope_res <= SlopeW'(w_q1);
                r_phase2 <= 1'b1;
                r_num    <= w_num;
                r_go     <= 1'b1;
            end
            if (w_wr) begin
                r_evalid[i_edge] <= 1'b1;
            end
        end
    end

    pip_ram #(.Width(SlopeW), .Depth(MaxVertices)) u_sl (.i_clk, .i_we(w_wr),
        .i_waddr(i_edge), .i_wdata((w_dy == '0) ? '0 : r_slope_res),
        .i_raddr(i_edge), .o_rdata(w_slope));
    pip_ram #(.Width(IcptW), .Depth(MaxVertices)) u_ic (.i_clk, .i_we(w_wr),
        .i_waddr(i_edge), .i_wdata(w_icpt_res), .i_raddr(i_edge), .o_rdata(w_icpt));

    assign o_status.div_done = w_wr;

    // Query: y*slope + intercept*256 < x*65536, at 57 bits.
    logic signed [15:0] r_px, r_py;
    logic signed [56:0] w_lhs, w_rhs;
    logic               w_cross, r_inside, r_evok;
    assign r_evok = r_evalid[i_edge];
    assign w_lhs = 57'(r_py) * 57'($signed(r_evok ? w_slope : '0))
                 + (57'($signed(r_evok ? w_icpt : '0)) <<< 8);
    assign w_rhs = 57'(r_px) <<< 16;
    assign w_cross = (($signed(w_y_cur) < r_py) && ($signed(w_y_prv) >= r_py)) ||
                     (($signed(w_y_prv) < r_py) && ($signed(w_y_cur) >= r_py));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
        end else if (i_cmd.clr) begin
            r_inside <= 1'b0;
        end else if (i_cmd.step && w_cross && (w_lhs < w_rhs)) begin
            r_inside <= ~r_inside;
        end
        if (i_cmd.cap) begin
            r_px <= i_cx;
            r_py <= i_cy;
        end
    end
    assign o_inside = r_inside;
endmodule
`default_nettype wire

@@ src/pip_ctrl.sv @@
`default_nettype none
module pip_ctrl #(
    parameter int MaxVertices = pip_pkg::MaxVerticesDefault
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [1:0]           i_mode,
    input  wire logic [4:0]           i_count,
    output pip_pkg::t_cmd             o_cmd,
    input  wire pip_pkg::t_status     i_status,
    output logic [$clog2(MaxVertices)-1:0] o_edge,
    output logic [$clog2(MaxVertices)-1:0] o_pred,
    input  wire logic                 i_inside,
    output logic                      o_rvalid,
    input  wire logic                 i_rready,
    output pip_pkg::t_result          o_res
);
    import pip_pkg::*;
    localparam int IdxW = $clog2(MaxVertices);
    typedef enum logic [2:0] {S_IDLE, S_CREAD, S_CGO, S_CDIV, S_QREAD, S_QSTEP,
                              S_QEND} t_state;
    t_state r_state;
    logic [IdxW:0] w_n;
    logic [IdxW-1:0] r_edge;
    logic [1:0] r_kind;

    assign w_n = ({2'b0, i_count} > 7'(MaxVertices)) ? (IdxW+1)'(MaxVertices)
                                                     : (IdxW+1)'(i_count);
    assign o_edge = r_edge;
    assign o_pred = (r_edge == '0) ? IdxW'(w_n - 1'b1) : r_edge - 1'b1;
    assign o_ready = (r_state == S_IDLE) && !o_rvalid;

    // The vertex memories have a registered read, so the divider start is issued
    // from S_CGO, after S_CREAD has read the vertices of the edge.
    always_comb begin
        o_cmd = '0;
        o_cmd.load = i_valid && o_ready && (i_mode == ModeLoad);
        o_cmd.cap  = i_valid && o_ready;
        o_cmd.clr  = i_valid && o_ready;
        o_cmd.div_start = (r_state == S_CGO);
        o_cmd.wr_edge = (r_state == S_CDIV);
        o_cmd.step = (r_state == S_QSTEP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            o_rvalid <= 1'b0;
            r_edge   <= '0;
            r_kind   <= '0;
            o_res    <= '0;
        end else begin
            if (o_rvalid && i_rready) o_rvalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_edge <= '0;
                        r_kind <= i_mode;
                        if (i_mode == ModeCommit && w_n != '0) r_state <= S_CREAD;
                        else if (i_mode == ModeQuery && w_n != '0) r_state <= S_QREAD;
                        else begin
                            o_res    <= '{kind: i_mode, in_poly: 1'b0};
                            o_rvalid <= 1'b1;
                        end
                    end
                end
                S_CREAD: r_state <= S_CGO;
                S_CGO: r_state <= S_CDIV;
                S_CDIV: begin
                    if (i_status.div_done) begin
                        if ((IdxW+1)'(r_edge) + 1'b1 == w_n) begin
                            o_res    <= '{kind: r_kind, in_poly: 1'b0};
                            o_rvalid <= 1'b1;
                            r_state  <= S_IDLE;
                        end else begin
                            r_edge  <= r_edge + 1'b1;
                            r_state <= S_CREAD;
                        end
                    end
                end
                S_QREAD: r_state <= S_QSTEP;
                S_QSTEP: begin
                    if ((IdxW+1)'(r_edge) + 1'b1 == w_n) r_state <= S_QEND;
                    else begin
                        r_edge  <= r_edge + 1'b1;
                        r_state <= S_QREAD;
                    end
                end
                S_QEND: begin
                    o_res    <= '{kind: r_kind, in_poly: i_inside};
                    o_rvalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
